// ----- rtl/core/heat_stencil_five_point_defines.svh -----
// Assertion macros for the heat stencil block.
// Each expects clk and rst_n in scope.
`ifndef HEAT_STENCIL_FIVE_POINT_DEFINES_SVH
`define HEAT_STENCIL_FIVE_POINT_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define HSFP_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("hsfp invariant violated");

`define HSFP_ASSERT_IMPLIES(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsfp implication violated");

`define HSFP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsfp next-cycle check violated");

`else

`define HSFP_ASSERT_ALWAYS(lbl, cond)
`define HSFP_ASSERT_IMPLIES(lbl, ante, cons)
`define HSFP_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

// ----- rtl/core/hsfp_pkg.sv -----
`default_nettype none
package hsfp_pkg;

  localparam int CELL_W         = 16;
  localparam int CFG_W          = 11;
  localparam int CFG_IDX_W      = 8;
  localparam int IDX_OUT_W      = 10;
  localparam int SUM_W          = 19;
  localparam int OUT_DATA_W     = 40;
  localparam int OUT_PAD_W      = OUT_DATA_W - CELL_W - 2 * IDX_OUT_W;
  localparam int GRID_RESET     = 1024;
  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 1024;

  // floor(s/5) = (s * ceil(2^22/5)) >> 22 for any s below 2^19
  localparam int DIV5_SHIFT = 22;
  localparam int DIV5_MUL_W = 20;
  localparam int PROD_W     = SUM_W + DIV5_MUL_W;
  localparam logic [DIV5_MUL_W-1:0] DIV5_MUL = 20'd838861;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 8'd1;

  typedef struct packed {
    logic en;
    logic par;
  } lsc_t;

endpackage
`default_nettype wire

// ----- rtl/core/heat_stencil_five_point.sv -----
// One Jacobi sweep of a 2D heat grid with a five-point stencil. Cells enter in raster
// order on in_* and each result is floor((center + up + down + left + right) / 5), with
// any neighbor outside the grid replaced by the center. Results leave in the order
// cell (r-1,c) as cell (r,c) arrives; on the last row the left neighbor (r,c-1) follows,
// and the grid's last input also yields the last cell, so one input gives up to three
// results and out_tlast marks the final one of each input. One cell is accepted per
// cycle while each input yields at most one result and the output is not stalled; a
// last-row input holds the input while its extra results leave, as the output port
// moves at most one result per cycle. Results pass the stage 1, stage 2 and output
// registers. Two line banks of MAX_WIDTH x 16 bits hold the previous two rows; no
// clearing pass is needed. Writing grid_width or grid_height restarts the grid at row
// 0, column 0; write them only while the block is idle.
`default_nettype none
`include "heat_stencil_five_point_defines.svh"
module heat_stencil_five_point import hsfp_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [CELL_W-1:0]     in_tdata,    // [15:0] cell_in
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  output logic [OUT_DATA_W-1:0]      out_tdata,   // [15:0] cell_out, [25:16] out_row,
                                                  // [35:26] out_col, [39:36] zero
  output logic                       out_tlast,   // run_last
  output logic                       out_tuser,   // [0] grid_done
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int RST_W_LAST = ((GRID_RESET > MAX_WIDTH) ? MAX_WIDTH : GRID_RESET) - 1;
  localparam int RST_H_LAST = ((GRID_RESET > MAX_HEIGHT) ? MAX_HEIGHT : GRID_RESET) - 1;

  // configuration
  logic          cfg_fire;
  logic          cfg_hit;
  logic [31:0]   cfg_ext;
  logic [31:0]   wl_ext;
  logic [31:0]   hl_ext;
  logic [CW-1:0] w_last_r;
  logic [RW-1:0] h_last_r;

  // input position
  logic          in_fire;
  logic [RW-1:0] row_r;
  logic [RW-1:0] row_nxt;
  logic [CW-1:0] col_r;
  logic [CW-1:0] col_nxt;
  logic          at_last_col;
  logic          at_last_row;

  // stage 1: line store read in flight
  logic              s1_v_r;
  logic [CELL_W-1:0] s1_x_r;
  logic [RW-1:0]     s1_row_r;
  logic [CW-1:0]     s1_col_r;
  logic              s1_last_row_r;
  logic              s1_last_col_r;
  logic              s1_r_ge1_r;
  logic              s1_r_ge2_r;
  logic              s1_c_ge1_r;
  logic              s1_c_ge2_r;
  logic              s1_adv;
  logic              s1_free;

  lsc_t              ls_req;
  logic [CW-1:0]     ls_col_rt;
  logic [CELL_W-1:0] ls_up;
  logic [CELL_W-1:0] ls_rt;

  // window over the previous row and the current row
  logic [CELL_W-1:0] h_ctr_r;
  logic [CELL_W-1:0] h_rt_r;
  logic [CELL_W-1:0] xp1_r;
  logic [CELL_W-1:0] xp2_r;
  logic [CELL_W-1:0] f_cur_r;
  logic [CELL_W-1:0] f_prev_r;

  logic [CELL_W-1:0] ctr_a;
  logic [CELL_W-1:0] lf_a;
  logic [CELL_W-1:0] rt_a;
  logic [CELL_W-1:0] up_a;
  logic [CELL_W-1:0] up_b;
  logic [CELL_W-1:0] lf_b;
  logic [CELL_W-1:0] up_c;
  logic [SUM_W-1:0]  sum_a;
  logic [SUM_W-1:0]  sum_b;
  logic [SUM_W-1:0]  sum_c;
  logic [2:0]        mask_new;

  // stage 2: pending results of one input
  logic              s2_v_r;
  logic [2:0]        s2_mask_r;
  logic [2:0]        mask_rest;
  logic [SUM_W-1:0]  s2_sum_a_r;
  logic [SUM_W-1:0]  s2_sum_b_r;
  logic [SUM_W-1:0]  s2_sum_c_r;
  logic [RW-1:0]     s2_row_r;
  logic [CW-1:0]     s2_col_r;
  logic              s2_fire;
  logic              s2_done;
  logic              s2_free;
  logic              sel_a;
  logic              sel_b;
  logic [SUM_W-1:0]  sel_sum;
  logic [31:0]       row_ext;
  logic [31:0]       col_ext;
  logic [PROD_W-1:0] prod;

  // output register
  logic                 out_take;
  logic                 out_valid_r;
  logic [CELL_W-1:0]    out_cell_r;
  logic [IDX_OUT_W-1:0] out_row_r;
  logic [IDX_OUT_W-1:0] out_col_r;
  logic                 out_last_r;
  logic                 out_done_r;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign cfg_hit   = cfg_fire && (cfg_index == REG_GRID_WIDTH || cfg_index == REG_GRID_HEIGHT);

  always_comb begin
    cfg_ext = 32'(cfg_data);
    if (cfg_ext < 32'd2) begin
      wl_ext = 32'd1;
    end else if (cfg_ext > 32'(MAX_WIDTH)) begin
      wl_ext = 32'(MAX_WIDTH - 1);
    end else begin
      wl_ext = cfg_ext - 32'd1;
    end
    if (cfg_ext == 32'd0) begin
      hl_ext = 32'd0;
    end else if (cfg_ext > 32'(MAX_HEIGHT)) begin
      hl_ext = 32'(MAX_HEIGHT - 1);
    end else begin
      hl_ext = cfg_ext - 32'd1;
    end
  end

  assign in_tready   = s1_free;
  assign in_fire     = in_tvalid && in_tready;
  assign at_last_col = (col_r == w_last_r);
  assign at_last_row = (row_r == h_last_r);

  always_comb begin
    row_nxt = row_r;
    col_nxt = col_r + CW'(1);
    if (at_last_col) begin
      col_nxt = '0;
      row_nxt = at_last_row ? '0 : row_r + RW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_last_r <= CW'(RST_W_LAST);
      h_last_r <= RW'(RST_H_LAST);
      row_r    <= '0;
      col_r    <= '0;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        REG_GRID_WIDTH: begin
          w_last_r <= wl_ext[CW-1:0];
          row_r    <= '0;
          col_r    <= '0;
        end
        REG_GRID_HEIGHT: begin
          h_last_r <= hl_ext[RW-1:0];
          row_r    <= '0;
          col_r    <= '0;
        end
        default: ;
      endcase
    end else if (in_fire) begin
      row_r <= row_nxt;
      col_r <= col_nxt;
    end
  end

  // line store: up value from this parity bank, right value from the other one
  assign ls_req.en  = in_fire;
  assign ls_req.par = row_r[0];
  assign ls_col_rt  = at_last_col ? col_r : col_r + CW'(1);

  hsfp_line_store #(
    .MAX_WIDTH (MAX_WIDTH)
  ) u_line_store (
    .clk    (clk),
    .req    (ls_req),
    .col    (col_r),
    .col_rt (ls_col_rt),
    .wdata  (in_tdata),
    .up_q   (ls_up),
    .rt_q   (ls_rt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_fire) begin
      s1_v_r <= 1'b1;
    end else if (s1_adv) begin
      s1_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_x_r        <= in_tdata;
      s1_row_r      <= row_r;
      s1_col_r      <= col_r;
      s1_last_row_r <= at_last_row;
      s1_last_col_r <= at_last_col;
      s1_r_ge1_r    <= (32'(row_r) >= 32'd1);
      s1_r_ge2_r    <= (32'(row_r) >= 32'd2);
      s1_c_ge1_r    <= (32'(col_r) >= 32'd1);
      s1_c_ge2_r    <= (32'(col_r) >= 32'd2);
    end
  end

  always_comb begin
    ctr_a = s1_c_ge1_r ? h_rt_r : f_prev_r;
    lf_a  = s1_c_ge1_r ? h_ctr_r : ctr_a;
    rt_a  = s1_last_col_r ? ctr_a : ls_rt;
    up_a  = s1_r_ge2_r ? ls_up : ctr_a;
    up_b  = s1_r_ge1_r ? h_ctr_r : xp1_r;
    lf_b  = s1_c_ge2_r ? xp2_r : xp1_r;
    up_c  = s1_r_ge1_r ? ctr_a : s1_x_r;
    sum_a = SUM_W'(ctr_a) + SUM_W'(up_a) + SUM_W'(s1_x_r) + SUM_W'(lf_a) + SUM_W'(rt_a);
    sum_b = SUM_W'(xp1_r) + SUM_W'(xp1_r) + SUM_W'(up_b) + SUM_W'(lf_b) + SUM_W'(s1_x_r);
    sum_c = SUM_W'(s1_x_r) + SUM_W'(s1_x_r) + SUM_W'(s1_x_r) + SUM_W'(up_c) + SUM_W'(xp1_r);
    mask_new = {s1_last_row_r && s1_last_col_r,
                s1_last_row_r && s1_c_ge1_r,
                s1_r_ge1_r};
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      h_ctr_r <= ctr_a;
      h_rt_r  <= ls_rt;
      xp1_r   <= s1_x_r;
      xp2_r   <= xp1_r;
      if (!s1_c_ge1_r) begin
        f_cur_r <= s1_x_r;
      end
      if (s1_last_col_r) begin
        f_prev_r <= f_cur_r;
      end
    end
  end

  assign out_take  = !out_valid_r || out_tready;
  assign s2_fire   = s2_v_r && out_take;
  assign mask_rest = s2_mask_r & (s2_mask_r - 3'd1);
  assign s2_done   = s2_fire && (mask_rest == 3'b000);
  assign s2_free   = !s2_v_r || s2_done;
  assign s1_adv    = s1_v_r && s2_free;
  assign s1_free   = !s1_v_r || s1_adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r    <= 1'b0;
      s2_mask_r <= 3'b000;
    end else if (s1_adv && (mask_new != 3'b000)) begin
      s2_v_r    <= 1'b1;
      s2_mask_r <= mask_new;
    end else if (s2_fire) begin
      s2_v_r    <= (mask_rest != 3'b000);
      s2_mask_r <= mask_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      s2_sum_a_r <= sum_a;
      s2_sum_b_r <= sum_b;
      s2_sum_c_r <= sum_c;
      s2_row_r   <= s1_row_r;
      s2_col_r   <= s1_col_r;
    end
  end

  always_comb begin
    sel_a   = s2_mask_r[0];
    sel_b   = !s2_mask_r[0] && s2_mask_r[1];
    sel_sum = sel_a ? s2_sum_a_r : (sel_b ? s2_sum_b_r : s2_sum_c_r);
    row_ext = 32'(s2_row_r) - (sel_a ? 32'd1 : 32'd0);
    col_ext = 32'(s2_col_r) - (sel_b ? 32'd1 : 32'd0);
    prod    = PROD_W'(sel_sum) * PROD_W'(DIV5_MUL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s2_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_fire) begin
      out_cell_r <= prod[DIV5_SHIFT +: CELL_W];
      out_row_r  <= row_ext[IDX_OUT_W-1:0];
      out_col_r  <= col_ext[IDX_OUT_W-1:0];
      out_last_r <= (mask_rest == 3'b000);
      out_done_r <= !sel_a && !sel_b;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{OUT_PAD_W{1'b0}}, out_col_r, out_row_r, out_cell_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

  `HSFP_ASSERT_ALWAYS(a_col_in_grid, col_r <= w_last_r)
  `HSFP_ASSERT_IMPLIES(a_pending_nonempty, s2_v_r, s2_mask_r != 3'b000)
  `HSFP_ASSERT_IMPLIES(a_done_is_last, out_valid_r && out_done_r, out_last_r)
  `HSFP_ASSERT_NEXT(a_cfg_restarts, cfg_hit, row_r == '0 && col_r == '0)

endmodule
`default_nettype wire

// ----- rtl/core/hsfp_line_store.sv -----
`default_nettype none
module hsfp_line_store import hsfp_pkg::*; #(
  parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
  input  wire logic                          clk,
  input  wire lsc_t                          req,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  col,
  input  wire logic [$clog2(MAX_WIDTH)-1:0]  col_rt,
  input  wire logic [CELL_W-1:0]             wdata,
  output logic      [CELL_W-1:0]             up_q,
  output logic      [CELL_W-1:0]             rt_q
);

  localparam int CW = $clog2(MAX_WIDTH);

  logic [CELL_W-1:0] bank0 [MAX_WIDTH];
  logic [CELL_W-1:0] bank1 [MAX_WIDTH];
  logic [CELL_W-1:0] q0_r;
  logic [CELL_W-1:0] q1_r;
  logic              par_r;
  logic [CW-1:0]     addr0;
  logic [CW-1:0]     addr1;

  // bank of the current row parity: read old value then overwrite
  assign addr0 = req.par ? col_rt : col;
  assign addr1 = req.par ? col : col_rt;

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (!req.par) begin
        bank0[col] <= wdata;
      end
      q0_r <= bank0[addr0];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.par) begin
        bank1[col] <= wdata;
      end
      q1_r <= bank1[addr1];
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      par_r <= req.par;
    end
  end

  assign up_q = par_r ? q1_r : q0_r;
  assign rt_q = par_r ? q0_r : q1_r;

endmodule
`default_nettype wire

// ----- tb/heat_stencil_five_point_tb.sv -----
`default_nettype none
module heat_stencil_five_point_tb;
  import hsfp_pkg::*;

  localparam int unsigned RANDOM_ITEMS     = 290;
  localparam int unsigned WIDE_ROW_CELLS   = 64;
  localparam int unsigned LONG_HOLD_AT     = 40;
  localparam int unsigned LONG_HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES    = 12;
  localparam int unsigned WATCHDOG_LIMIT   = 2000;
  localparam int unsigned LINE_DEPTH       = 2 * DEF_MAX_WIDTH;

  typedef struct {
    logic [CELL_W-1:0]    temp;
    logic [IDX_OUT_W-1:0] row;
    logic [IDX_OUT_W-1:0] col;
    logic                 tlast;
    logic                 done;
  } cell_res_t;

  typedef enum logic {ROW_CFG, ROW_CELL} row_kind_t;

  typedef struct {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [CELL_W-1:0]    val;
    bit                   typed;
    logic [CELL_W-1:0]    want;
  } stim_row_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [CELL_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_W-1:0]      cfg_data = '0;

  always #10 clk = ~clk;

  heat_stencil_five_point i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Shadow of the block: registers, two line banks, raster position
  logic [CFG_W-1:0]  grid_w_reg = 11'd1024;
  logic [CFG_W-1:0]  grid_h_reg = 11'd1024;
  logic [CELL_W-1:0] line_mem [0:LINE_DEPTH-1];
  int unsigned       cur_row = 0;
  int unsigned       cur_col = 0;
  cell_res_t         pending_cells [$];
  int unsigned       errors = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;

  function automatic int unsigned cols_in_use();
    int unsigned w;
    w = 32'(grid_w_reg);
    if (w < 2) w = 2;
    if (w > DEF_MAX_WIDTH) w = DEF_MAX_WIDTH;
    return w;
  endfunction

  function automatic int unsigned rows_in_use();
    int unsigned h;
    h = 32'(grid_h_reg);
    if (h < 1) h = 1;
    if (h > DEF_MAX_HEIGHT) h = DEF_MAX_HEIGHT;
    return h;
  endfunction

  function automatic int unsigned line_get(int unsigned r, int unsigned c);
    int unsigned idx;
    idx = (r & 1) * DEF_MAX_WIDTH + c;
    if (idx >= LINE_DEPTH) return 0;
    return 32'(line_mem[idx]);
  endfunction

  function automatic cell_res_t stencil(int unsigned ctr, int unsigned up, int unsigned dn,
                                        int unsigned lf, int unsigned rt, int unsigned r,
                                        int unsigned c, bit done);
    cell_res_t s;
    s.temp  = CELL_W'((ctr + up + dn + lf + rt) / 5);
    s.row   = IDX_OUT_W'(r);
    s.col   = IDX_OUT_W'(c);
    s.tlast = 1'b0;
    s.done  = done;
    return s;
  endfunction

  // One accepted cell: queue the cells it completes, then store it and advance
  task automatic jacobi_update(input logic [CELL_W-1:0] x, input bit typed,
                               input logic [CELL_W-1:0] typed_temp);
    cell_res_t   res [3];
    int          n;
    int unsigned w, h, r, c, idx, ctr, up, lf, rt;
    bit          last_row, last_cell;
    n = 0;
    w = cols_in_use();
    h = rows_in_use();
    r = cur_row;
    c = cur_col;
    last_row = (r + 1 == h);
    last_cell = last_row && (c + 1 == w);
    if (r >= DEF_MAX_HEIGHT || c >= w) begin
      r = 0;
      c = 0;
      last_row = (h == 1);
      last_cell = 1'b0;
    end
    if (r >= 1) begin
      ctr = line_get(r - 1, c);
      up = (r >= 2) ? line_get(r, c) : ctr;
      lf = (c >= 1) ? line_get(r - 1, c - 1) : ctr;
      rt = (c + 1 < w) ? line_get(r - 1, c + 1) : ctr;
      res[n] = stencil(ctr, up, 32'(x), lf, rt, r - 1, c, 1'b0);
      n++;
    end
    if (last_row && c >= 1) begin
      ctr = line_get(r, c - 1);
      up = (r >= 1) ? line_get(r - 1, c - 1) : ctr;
      lf = (c >= 2) ? line_get(r, c - 2) : ctr;
      res[n] = stencil(ctr, up, ctr, lf, 32'(x), r, c - 1, 1'b0);
      n++;
    end
    if (last_cell) begin
      up = (r >= 1) ? line_get(r - 1, c) : 32'(x);
      lf = line_get(r, c - 1);
      res[n] = stencil(32'(x), up, 32'(x), lf, 32'(x), r, c, 1'b1);
      n++;
    end
    idx = (r & 1) * DEF_MAX_WIDTH + c;
    if (idx < LINE_DEPTH) line_mem[idx] = x;
    if (n > 0) res[n - 1].tlast = 1'b1;
    for (int i = 0; i < n; i++) begin
      if (typed) res[i].temp = typed_temp;
      pending_cells.push_back(res[i]);
    end
    if (last_cell) begin
      cur_row = 0;
      cur_col = 0;
    end else if (c + 1 >= w) begin
      cur_col = 0;
      cur_row = r + 1;
    end else begin
      cur_col = c + 1;
      cur_row = r;
    end
  endtask

  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 31) == 0) tx_calm = !tx_calm;
    return tx_calm ? 0 : $urandom_range(0, 3);
  endfunction

  function automatic logic [CELL_W-1:0] draw_temp();
    case ($urandom_range(0, 7))
      0: return 16'h0000;
      1: return 16'hFFFF;
      2: return 16'h8000;
      3: return 16'h7FFF;
      default: return CELL_W'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_width();
    case ($urandom_range(0, 9))
      0: return CFG_W'($urandom_range(0, 1));
      1: return CFG_W'($urandom_range(9, 24));
      default: return CFG_W'($urandom_range(2, 8));
    endcase
  endfunction

  function automatic logic [CFG_W-1:0] pick_height();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return CFG_W'($urandom_range(9, 12));
      default: return CFG_W'($urandom_range(1, 6));
    endcase
  endfunction

  task automatic push_cell(input logic [CELL_W-1:0] v, input bit typed,
                           input logic [CELL_W-1:0] typed_temp);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= v;
    do @(posedge clk); while (!in_tready);
    jacobi_update(v, typed, typed_temp);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == REG_GRID_WIDTH) grid_w_reg = val;
    else if (idx == REG_GRID_HEIGHT) grid_h_reg = val;
    cur_row = 0;
    cur_col = 0;
    @(posedge clk);
  endtask

  // Input stops, every expected result drains, then a settle wait lets cells still in flight finish
  task automatic quiesce();
    in_tvalid <= 1'b0;
    while (pending_cells.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  stim_row_t dir_tab [0:29];
  initial dir_tab = '{
    // reset geometry 1024x1024: first row yields nothing
    '{ROW_CELL, '0, 16'hFFFF, 1'b1, 16'h0000},
    '{ROW_CELL, '0, 16'h0000, 1'b1, 16'h0000},
    '{ROW_CELL, '0, 16'h8000, 1'b1, 16'h0000},
    // width 0 -> 2, height 0 -> 1: single row, last cell gives two results
    '{ROW_CFG, REG_GRID_WIDTH, 16'd0, 1'b0, 16'h0000},
    '{ROW_CFG, REG_GRID_HEIGHT, 16'd0, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'hFFFF, 1'b1, 16'hFFFF},
    '{ROW_CELL, '0, 16'hFFFF, 1'b1, 16'hFFFF},
    // width 1 -> 2, height 2: flat zero grid, last input gives three results
    '{ROW_CFG, REG_GRID_WIDTH, 16'd1, 1'b0, 16'h0000},
    '{ROW_CFG, REG_GRID_HEIGHT, 16'd2, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h0000, 1'b1, 16'h0000},
    '{ROW_CELL, '0, 16'h0000, 1'b1, 16'h0000},
    '{ROW_CELL, '0, 16'h0000, 1'b1, 16'h0000},
    '{ROW_CELL, '0, 16'h0000, 1'b1, 16'h0000},
    // 3x3 with corners, edges and an interior cell
    '{ROW_CFG, REG_GRID_WIDTH, 16'd3, 1'b0, 16'h0000},
    '{ROW_CFG, REG_GRID_HEIGHT, 16'd3, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h8000, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h0001, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h7FFF, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h5555, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'hAAAA, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h8000, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h1234, 1'b0, 16'h0000},
    // height above range -> 1024, partial grid
    '{ROW_CFG, REG_GRID_WIDTH, 16'd2, 1'b0, 16'h0000},
    '{ROW_CFG, REG_GRID_HEIGHT, 16'd2047, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'hFFFF, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h0000, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'hC3A5, 1'b0, 16'h0000},
    '{ROW_CELL, '0, 16'h3C5A, 1'b0, 16'h0000}
  };

  initial begin : stimulus
    int unsigned random_sent;
    int unsigned grids;
    int unsigned cells;
    random_sent = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_tab[i]) begin
      if (dir_tab[i].kind == ROW_CFG) begin
        quiesce();
        write_reg(dir_tab[i].idx, dir_tab[i].val[CFG_W-1:0]);
      end else begin
        push_cell(dir_tab[i].val, dir_tab[i].typed, dir_tab[i].want);
      end
    end
    // width above range -> 1024, first cells of one row; the long output hold lands here
    quiesce();
    write_reg(REG_GRID_WIDTH, 11'd2047);
    write_reg(REG_GRID_HEIGHT, 11'd1);
    repeat (WIDE_ROW_CELLS) push_cell(draw_temp(), 1'b0, '0);
    while (random_sent < RANDOM_ITEMS) begin
      quiesce();
      case ($urandom_range(0, 2))
        0: begin
          write_reg(REG_GRID_WIDTH, pick_width());
          write_reg(REG_GRID_HEIGHT, pick_height());
        end
        1: write_reg(REG_GRID_WIDTH, pick_width());
        default: write_reg(REG_GRID_HEIGHT, pick_height());
      endcase
      grids = $urandom_range(1, 2);
      for (int g = 0; g < grids; g++) begin
        cells = cols_in_use() * rows_in_use();
        if (g == grids - 1 && $urandom_range(0, 5) == 0) cells = $urandom_range(1, cells);
        if (cells > RANDOM_ITEMS - random_sent) cells = RANDOM_ITEMS - random_sent;
        repeat (cells) begin
          push_cell(draw_temp(), 1'b0, '0);
          random_sent++;
        end
      end
    end
    quiesce();
    if (errors == 0) begin
      $display("heat_stencil_five_point_tb: done, clean");
    end else begin
      $display("heat_stencil_five_point_tb: done, errors");
    end
    $finish;
  end

  // Output backpressure: random stall per transaction, one long hold
  int unsigned hold_left = 0;
  int unsigned seen_results = 0;
  always @(posedge clk) begin : rx_ready
    int unsigned stall;
    if (!rst_n) begin
      out_tready <= 1'b0;
      hold_left <= 0;
      seen_results <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      if (hold_left == 1) out_tready <= 1'b1;
    end else if (!out_tready) begin
      out_tready <= 1'b1;
    end else if (out_tvalid) begin
      seen_results <= seen_results + 1;
      if ($urandom_range(0, 31) == 0) rx_calm = !rx_calm;
      stall = rx_calm ? 0 : $urandom_range(0, 3);
      if (seen_results + 1 == LONG_HOLD_AT) stall = LONG_HOLD_CYCLES;
      if (stall != 0) begin
        out_tready <= 1'b0;
        hold_left <= stall;
      end
    end
  end

  always @(posedge clk) begin : result_check
    cell_res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_cells.size() == 0) begin
        $error("result transaction with nothing expected: tdata %0h", out_tdata);
        errors++;
      end else begin
        want = pending_cells.pop_front();
        if (out_tdata[CELL_W-1:0] !== want.temp) begin
          $error("cell_out: expected %0h, actual %0h", want.temp, out_tdata[CELL_W-1:0]);
          errors++;
        end
        if (out_tdata[CELL_W +: IDX_OUT_W] !== want.row) begin
          $error("out_row: expected %0d, actual %0d", want.row, out_tdata[CELL_W +: IDX_OUT_W]);
          errors++;
        end
        if (out_tdata[CELL_W+IDX_OUT_W +: IDX_OUT_W] !== want.col) begin
          $error("out_col: expected %0d, actual %0d", want.col,
                 out_tdata[CELL_W+IDX_OUT_W +: IDX_OUT_W]);
          errors++;
        end
        if (out_tdata[OUT_DATA_W-1 -: OUT_PAD_W] !== '0) begin
          $error("pad: expected 0, actual %0h", out_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
          errors++;
        end
        if (out_tlast !== want.tlast) begin
          $error("run_last: expected %0b, actual %0b", want.tlast, out_tlast);
          errors++;
        end
        if (out_tuser !== want.done) begin
          $error("grid_done: expected %0b, actual %0b", want.done, out_tuser);
          errors++;
        end
      end
    end
  end

  int unsigned quiet_cycles = 0;
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("heat_stencil_five_point_tb: done, errors");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
`default_nettype wire
